[hw/rtl/stdf_pkg.sv]
// Shared types and constants for the serial tunnel deframer.
// Used by stdf_step, stdf_out_buf and serial_tunnel_deframer; no dependencies.
package stdf_pkg;

  // Number of destination slots known to the deframer.
  localparam int unsigned NUM_SLOTS = 2;

  // Header layout: eight bytes, position counter saturates once past it.
  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned POS_W     = $clog2(HDR_BYTES + 1);

  localparam logic [POS_W-1:0] POS_WORDS   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SLOT    = POS_W'(3);
  localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(5);
  localparam logic [POS_W-1:0] POS_JUDGE   = POS_W'(HDR_BYTES - 1);
  localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(HDR_BYTES);

  // Configuration register indexes.
  localparam logic CFG_SLOT_OPEN_MASK = 1'b0;
  localparam logic CFG_RAW_SLOT1_MODE = 1'b1;

  // Message status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_HDR  = 3'd1,
    ST_CLOSED   = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_TRUNC    = 3'd4
  } status_t;

  // Per-message parsing state.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [7:0]       word_count;
    logic [7:0]       slot_index;
    logic [15:0]      payload_length;
    logic [15:0]      forward_remaining;
    status_t          message_status;
  } stdf_state_t;

  // One result item.
  typedef struct packed {
    logic       has_data;
    logic [7:0] data_byte;
    logic       dest_slot;
    logic       last_data;
    logic       msg_done;
    status_t    status;
  } stdf_result_t;

endpackage

[hw/rtl/serial_tunnel_deframer.sv]
// Serial tunnel deframer top level: input register, state, config, result buffer.
// Path: a byte's result passes the input register, then the combinational step into the
// result buffer, then the output stream.
// Throughput: one byte per cycle while the two-entry result buffer has room, set by the
// combinational step between the input register and the result buffer.
// Reset (rst, synchronous): clears message state, config registers and both buffers.
module serial_tunnel_deframer
  import stdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // in_end
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] data_byte, [10:8] status, [15:11] zero
  output logic [2:0]  m_tuser,   // [0] has_data, [1] dest_slot, [2] msg_done
  output logic        m_tlast,   // last_data
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_end;
  logic         fire;
  logic         buf_space;
  logic [1:0]   slot_open_mask;
  logic         raw_second_slot_mode;
  stdf_state_t  state;
  stdf_state_t  state_next;
  stdf_result_t step_res;
  logic         step_res_valid;
  stdf_result_t out_res;

  assign cfg_ready = 1'b1;

  // A held byte is processed whenever the result buffer has room.
  assign fire     = in_valid && buf_space;
  assign s_tready = !in_valid || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_end  <= s_tlast;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_open_mask       <= '0;
      raw_second_slot_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLOT_OPEN_MASK: slot_open_mask       <= cfg_data;
        CFG_RAW_SLOT1_MODE: raw_second_slot_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Message state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  stdf_step u_step (
    .cur                  (state),
    .in_byte              (in_byte),
    .in_end               (in_end),
    .slot_open_mask       (slot_open_mask),
    .raw_second_slot_mode (raw_second_slot_mode),
    .nxt                  (state_next),
    .res                  (step_res),
    .res_valid            (step_res_valid)
  );

  stdf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire && step_res_valid),
    .push_data (step_res),
    .space     (buf_space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  // Pack the result onto the stream fields.
  assign m_tdata = {5'd0, out_res.status, out_res.data_byte};
  assign m_tuser = {out_res.msg_done, out_res.dest_slot, out_res.has_data};
  assign m_tlast = out_res.last_data;

  // A message end always returns the parser to the start of a header.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && in_end) |=> (state.pos == '0 && state.forward_remaining == 16'd0))
    else $error("state not cleared after message end");
  // No payload is pending while the header is still being taken in.
  a_hdr_no_fwd: assert property (@(posedge clk) disable iff (rst)
    (state.pos < POS_PAYLOAD) |-> (state.forward_remaining == 16'd0))
    else $error("payload pending inside header");
  // Every result either carries data or closes a message.
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_res.has_data) |-> out_res.msg_done)
    else $error("empty result on the output");

endmodule

[hw/rtl/stdf_step.sv]
// Combinational per-byte step of the deframer: header capture, judgement,
// payload forwarding and end-of-message status. Depends on stdf_pkg.
module stdf_step
  import stdf_pkg::*;
(
  input  stdf_state_t  cur,
  input  logic [7:0]   in_byte,
  input  logic         in_end,
  input  logic [1:0]   slot_open_mask,
  input  logic         raw_second_slot_mode,
  output stdf_state_t  nxt,
  output stdf_result_t res,
  output logic         res_valid
);

  logic [9:0]  room;
  logic        slot_open;
  stdf_state_t upd;

  // Payload room in bytes: (word count - 1) * 4.
  assign room = {cur.word_count - 8'd1, 2'b00};
  assign slot_open = (cur.slot_index < 8'd2) && slot_open_mask[cur.slot_index[0]];

  // Main step: update the state and build the result for this byte.
  always_comb begin
    upd = cur;
    res = '0;
    if (cur.pos < POS_PAYLOAD) begin
      case (cur.pos)
        POS_WORDS:  upd.word_count = in_byte;
        POS_SLOT:   upd.slot_index = in_byte;
        POS_LEN_HI: upd.payload_length[15:8] = in_byte;
        POS_LEN_LO: upd.payload_length[7:0] = in_byte;
        POS_JUDGE: begin
          upd.forward_remaining = '0;
          if (cur.slot_index >= 8'(NUM_SLOTS) || cur.word_count <= 8'd1) begin
            upd.message_status = ST_BAD_HDR;
          end else if (!slot_open) begin
            upd.message_status = ST_CLOSED;
          end else if (cur.slot_index == 8'd1 && raw_second_slot_mode) begin
            upd.message_status    = ST_OK;
            upd.forward_remaining = 16'(room);
          end else if (cur.payload_length > 16'(room)) begin
            upd.message_status = ST_TOO_LONG;
          end else begin
            upd.message_status    = ST_OK;
            upd.forward_remaining = cur.payload_length;
          end
        end
        default: ;
      endcase
    end else if (cur.forward_remaining != 16'd0) begin
      upd.forward_remaining = cur.forward_remaining - 16'd1;
      res.has_data  = 1'b1;
      res.data_byte = in_byte;
      res.dest_slot = cur.slot_index[0];
      res.last_data = (cur.forward_remaining == 16'd1);
    end

    // Position saturates once the header is behind us.
    if (cur.pos < POS_PAYLOAD) begin
      upd.pos = cur.pos + POS_W'(1);
    end

    nxt = upd;
    // Close the message on the end mark.
    if (in_end) begin
      res.msg_done = 1'b1;
      if (cur.pos < POS_JUDGE) begin
        res.status = ST_TRUNC;
      end else if (upd.message_status != ST_OK) begin
        res.status = upd.message_status;
      end else if (upd.forward_remaining != 16'd0) begin
        res.status = ST_TRUNC;
      end else begin
        res.status = ST_OK;
      end
      nxt = '0;
    end
    res_valid = res.has_data | res.msg_done;
  end

endmodule

[hw/rtl/stdf_out_buf.sv]
// Two-entry result buffer that decouples the step logic from the output
// stream's back-pressure. Depends on stdf_pkg.
module stdf_out_buf
  import stdf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  stdf_result_t push_data,
  output logic         space,
  output logic         out_valid,
  input  logic         out_ready,
  output stdf_result_t out_data
);

  stdf_result_t entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign space     = (count != 2'd2);
  assign out_data  = entries[rd_ptr];

  // Storage for buffered results.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // The buffer never overflows and the count matches the pointers.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (space || pop))
    else $error("result buffer written while full");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) |-> (wr_ptr != rd_ptr))
    else $error("result buffer pointers disagree with count");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for serial_tunnel_deframer: byte-stream messages in,
// forwarded payload and message status out. Depends on stdf_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_top;
  import stdf_pkg::*;

  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned PHASE_ITEMS = 105;
  localparam int unsigned BODY_CAP = 48;

  typedef struct {
    logic [7:0]  data;
    logic        fin;
    int unsigned gap;
  } tx_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] in_byte
  logic        s_tlast = 1'b0; // in_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [7:0] data_byte, [10:8] status, [15:11] zero
  logic [2:0]  m_tuser;        // [0] has_data, [1] dest_slot, [2] msg_done
  logic        m_tlast;        // last_data
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [1:0]  cfg_data = '0;

  // Bytes waiting to be sent and results the deframer still owes us.
  tx_item_t     tx_bytes[$];
  stdf_result_t due_results[$];

  // Our own copy of the configuration and of the per-message parser state.
  logic [1:0]  open_mask = '0;
  logic        raw_slot1 = 1'b0;
  logic [15:0] pos_cnt = '0;
  logic [7:0]  hdr_words = '0;
  logic [7:0]  hdr_slot = '0;
  logic [15:0] hdr_count = '0;
  logic [15:0] fwd_left = '0;
  status_t     verdict = ST_OK;

  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned bytes_fwd = 0;
  int unsigned msgs_sent = 0;
  int unsigned status_seen[5] = '{default: 0};
  int unsigned errors = 0;
  int unsigned gap_wait = 0;
  int unsigned rx_hold = 0;
  int unsigned idle_cycles = 0;
  bit          rx_calm = 1'b0;
  tx_item_t     drv_item;
  stdf_result_t drv_res;
  stdf_result_t want;

  serial_tunnel_deframer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Advance the parser by one byte; returns 1 when the byte produces a result.
  function automatic bit deframe_byte(input logic [7:0] b, input logic fin,
                                      output stdf_result_t r);
    logic [15:0] at;
    logic [15:0] room;
    at = pos_cnt;
    r = '0;
    if (at < HDR_BYTES) begin
      case (at[POS_W-1:0])
        POS_WORDS:  hdr_words = b;
        POS_SLOT:   hdr_slot = b;
        POS_LEN_HI: hdr_count[15:8] = b;
        POS_LEN_LO: hdr_count[7:0] = b;
        POS_JUDGE: begin
          // Header complete: decide whether and how much to forward.
          room = (16'(hdr_words) - 16'd1) << 2;
          fwd_left = '0;
          if (hdr_slot >= NUM_SLOTS || hdr_words <= 8'd1) begin
            verdict = ST_BAD_HDR;
          end else if (!open_mask[hdr_slot[0]]) begin
            verdict = ST_CLOSED;
          end else if (hdr_slot[0] && raw_slot1) begin
            verdict = ST_OK;
            fwd_left = room;
          end else if (hdr_count > room) begin
            verdict = ST_TOO_LONG;
          end else begin
            verdict = ST_OK;
            fwd_left = hdr_count;
          end
        end
        default: ;
      endcase
    end else if (fwd_left != '0) begin
      fwd_left = fwd_left - 16'd1;
      r.has_data = 1'b1;
      r.data_byte = b;
      r.dest_slot = hdr_slot[0];
      r.last_data = (fwd_left == '0);
    end
    if (pos_cnt != 16'hFFFF) pos_cnt = pos_cnt + 16'd1;
    // The final byte closes the message and clears the parser.
    if (fin) begin
      r.msg_done = 1'b1;
      if (at < HDR_BYTES - 1) r.status = ST_TRUNC;
      else if (verdict != ST_OK) r.status = verdict;
      else if (fwd_left != '0) r.status = ST_TRUNC;
      else r.status = ST_OK;
      pos_cnt = '0;
      hdr_words = '0;
      hdr_slot = '0;
      hdr_count = '0;
      fwd_left = '0;
      verdict = ST_OK;
    end
    return r.has_data || r.msg_done;
  endfunction

  task automatic check_field(input string what, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, exp_val, act_val);
    end
  endtask

  // Write one configuration register and mirror it in the model.
  task automatic write_reg(input logic idx, input logic [1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == CFG_SLOT_OPEN_MASK) open_mask = val;
    else raw_slot1 = val[0];
  endtask

  // Queue one message: hdr_len header bytes (eight for a full header), then body bytes.
  task automatic queue_msg(input logic [7:0] words, input logic [7:0] slot,
                           input logic [15:0] count, input int unsigned body,
                           input int unsigned hdr_len);
    logic [7:0]  hdr[8];
    int unsigned total;
    bit          calm;
    tx_item_t    it;
    hdr[0] = 8'($urandom);
    hdr[1] = words;
    hdr[2] = 8'($urandom);
    hdr[3] = slot;
    hdr[4] = count[15:8];
    hdr[5] = count[7:0];
    hdr[6] = 8'($urandom);
    hdr[7] = 8'($urandom);
    total = (hdr_len < HDR_BYTES) ? hdr_len : HDR_BYTES + body;
    calm = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < total; i++) begin
      it.data = (i < HDR_BYTES) ? hdr[i] : 8'($urandom);
      it.fin = (i == total - 1);
      it.gap = calm ? 0 : $urandom_range(0, 7);
      tx_bytes.push_back(it);
    end
    items_queued += total;
    msgs_sent++;
  endtask

  // Mostly well-formed messages for slots 0 and 1, with some bad headers and cut-offs.
  task automatic queue_random_msg();
    int unsigned pick;
    logic [7:0]  words;
    logic [7:0]  slot;
    logic [15:0] count;
    int unsigned room;
    int unsigned fwd;
    int unsigned body;
    int unsigned hdr_len;
    pick = $urandom_range(0, 99);
    if (pick < 6) words = 8'($urandom_range(0, 1));
    else if (pick < 12) words = 8'($urandom_range(2, 255));
    else words = 8'($urandom_range(2, 6));
    slot = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(2, 255)) : 8'($urandom_range(0, 1));
    room = (words > 1) ? (int'(words) - 1) * 4 : 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) count = 16'($urandom_range(0, room));
    else if (pick < 65) count = 16'(room);
    else if (pick < 75) count = '0;
    else if (pick < 88) count = 16'(room + $urandom_range(1, 8));
    else count = 16'($urandom);
    fwd = (slot == 8'd1 && raw_slot1) ? room : count;
    if (fwd > BODY_CAP) fwd = BODY_CAP;
    pick = $urandom_range(0, 99);
    hdr_len = HDR_BYTES;
    body = 0;
    if (pick < 8) begin
      hdr_len = $urandom_range(1, 7);
    end else if (pick < 20) begin
      body = $urandom_range(0, fwd);
    end else begin
      body = fwd + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4));
    end
    queue_msg(words, slot, count, body, hdr_len);
  endtask

  // Hold the sender until every byte is taken and every result has come back.
  task automatic drain();
    do @(negedge clk); while (items_taken != items_queued || due_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // Sender: one byte transaction at a time, predicting its result on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_wait = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        items_taken++;
        if (deframe_byte(s_tdata, s_tlast, drv_res)) due_results.push_back(drv_res);
      end
      if (!s_tvalid || s_tready) begin
        if (tx_bytes.size() != 0 && gap_wait >= tx_bytes[0].gap) begin
          drv_item = tx_bytes.pop_front();
          s_tdata <= drv_item.data;
          s_tlast <= drv_item.fin;
          s_tvalid <= 1'b1;
          gap_wait = 0;
        end else begin
          s_tvalid <= 1'b0;
          if (tx_bytes.size() != 0) gap_wait++;
        end
      end
    end
  end

  // Receiver: checks each result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result, expected none, got tdata=%h tuser=%b tlast=%b",
                   $time, m_tdata, m_tuser, m_tlast);
        end else begin
          want = due_results.pop_front();
          check_field("has_data", 16'(want.has_data), 16'(m_tuser[0]));
          check_field("data_byte", 16'(want.data_byte), 16'(m_tdata[7:0]));
          check_field("dest_slot", 16'(want.dest_slot), 16'(m_tuser[1]));
          check_field("last_data", 16'(want.last_data), 16'(m_tlast));
          check_field("msg_done", 16'(want.msg_done), 16'(m_tuser[2]));
          check_field("status", 16'(want.status), 16'(m_tdata[10:8]));
          check_field("tdata padding", 16'd0, 16'(m_tdata[15:11]));
        end
        if (m_tuser[0] === 1'b1) bytes_fwd++;
        if (m_tuser[2] === 1'b1 && m_tdata[10:8] <= 3'(ST_TRUNC)) status_seen[m_tdata[10:8]]++;
        rx_hold = rx_calm ? 0 : $urandom_range(0, 7);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: stop the run if no transaction of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: directed messages first, then random phases under varied settings.
  initial begin
    logic [1:0]  mask_plan[7];
    logic        raw_plan[7];
    int unsigned stop_at;
    mask_plan = '{2'b11, 2'b01, 2'b10, 2'b11, 2'b00, 2'b11, 2'b01};
    raw_plan = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Both slots open: a one-byte message, an empty payload and a small payload.
    write_reg(CFG_SLOT_OPEN_MASK, 2'b11);
    write_reg(CFG_RAW_SLOT1_MODE, 2'b00);
    queue_msg(8'd2, 8'd0, 16'd0, 0, 1);
    queue_msg(8'd2, 8'd0, 16'd0, 0, HDR_BYTES);
    queue_msg(8'd2, 8'd1, 16'd4, 4, HDR_BYTES);
    drain();

    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_SLOT_OPEN_MASK, mask_plan[p]);
      write_reg(CFG_RAW_SLOT1_MODE, {1'b0, raw_plan[p]});
      rx_calm = (p % 3 == 1);
      stop_at = items_queued + PHASE_ITEMS;
      while (items_queued < stop_at) queue_random_msg();
      drain();
    end

    $display("Sent %0d bytes in %0d messages; %0d results checked, %0d payload bytes forwarded.",
             items_taken, msgs_sent, results_seen, bytes_fwd);
    $display("Message status counts: ok %0d, bad header %0d, closed %0d, too long %0d, cut %0d.",
             status_seen[ST_OK], status_seen[ST_BAD_HDR], status_seen[ST_CLOSED],
             status_seen[ST_TOO_LONG], status_seen[ST_TRUNC]);
    if (errors == 0 && due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
